// File: rtl/core/segment_intersection_test_macros.svh
// Assertion macros for the segment intersection test RTL
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset
`define SIT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment intersection check failed");
// Next-cycle implication
`define SIT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment intersection check failed");
`else
`define SIT_ASSERT_NOW(label, ante, cons)
`define SIT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/sit_pkg.sv
// Types and constants shared by the segment intersection test pipeline
package sit_pkg;

  localparam int FIELD_WIDTH = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_FIELDS = 8;
  localparam int NUM_ORIENT = 4;

  typedef enum logic [1:0] {
    ORIENT_COLLINEAR = 2'd0,
    ORIENT_POS       = 2'd1,
    ORIENT_NEG       = 2'd2
  } orient_t;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

// File: rtl/core/segment_intersection_test.sv
// Pipeline: 4 register stages (diff, multiply, subtract, decide); out_valid follows v1, v2 and v3 in turn.
// Throughput: one segment pair per cycle while no stall holds it; each stage loads when it is empty or drains.
// The four product pairs use four pairs of (COORD_WIDTH+1)-bit multipliers in stage 2.
// A stall on the output holds the stages that are full; in_stall rises only once every stage is full.
// Synchronous active-high rst clears all stage valid bits; data registers are not reset.
// Top level of the segment intersection test pipeline
`include "segment_intersection_test_macros.svh"

module segment_intersection_test #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] a_start_x,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] a_start_y,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] a_end_x,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] a_end_y,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] b_start_x,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] b_start_y,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] b_end_x,
  input  logic signed [sit_pkg::FIELD_WIDTH-1:0] b_end_y,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  segments_meet
);

  sit_pkg::stage_en_t en;

  logic v1;
  logic v2;
  logic v3;

  logic [sit_pkg::FIELD_WIDTH-1:0]      fld   [sit_pkg::NUM_FIELDS];
  logic signed [COORD_WIDTH:0]          d     [sit_pkg::NUM_ORIENT][4];
  logic [sit_pkg::NUM_ORIENT-1:0]       box1;
  logic [sit_pkg::NUM_ORIENT-1:0]       box2;
  logic [sit_pkg::NUM_ORIENT-1:0]       box3;
  sit_pkg::orient_t                     code  [sit_pkg::NUM_ORIENT];

  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    en.s4 = !out_valid || !out_stall;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) begin
        v1 <= in_valid;
      end
      if (en.s2) begin
        v2 <= v1;
      end
      if (en.s3) begin
        v3 <= v2;
      end
      if (en.s4) begin
        out_valid <= v3;
      end
    end
  end

  assign fld[0] = a_start_x;
  assign fld[1] = a_start_y;
  assign fld[2] = a_end_x;
  assign fld[3] = a_end_y;
  assign fld[4] = b_start_x;
  assign fld[5] = b_start_y;
  assign fld[6] = b_end_x;
  assign fld[7] = b_end_y;

  sit_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk (clk),
    .en  (en),
    .fld (fld),
    .d   (d),
    .box (box1)
  );

  for (genvar k = 0; k < sit_pkg::NUM_ORIENT; k++) begin : g_orient
    sit_orient #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_orient (
      .clk  (clk),
      .en   (en),
      .d    (d[k]),
      .code (code[k])
    );
  end

  // carry the box tests alongside the multiply and subtract stages
  always_ff @(posedge clk) begin
    if (en.s2) begin
      box2 <= box1;
    end
    if (en.s3) begin
      box3 <= box2;
    end
  end

  sit_decide u_decide (
    .clk  (clk),
    .en   (en),
    .code (code),
    .box  (box3),
    .meet (segments_meet)
  );

  `SIT_ASSERT_NOW(a_stall_only_when_full, in_stall, v1 && v2 && v3 && out_valid && out_stall)
  `SIT_ASSERT_NOW(a_result_from_stage3, $rose(out_valid), $past(v3))
  `SIT_ASSERT_NEXT(a_stage2_holds, v2 && !en.s3, v2)
  `SIT_ASSERT_NEXT(a_stage1_holds, v1 && !en.s2, v1)

endmodule

// File: rtl/core/sit_front.sv
// Stage 1: coordinate extraction, cross product differences and bounding box tests
module sit_front #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  sit_pkg::stage_en_t                     en,
  input  logic [sit_pkg::FIELD_WIDTH-1:0]        fld [sit_pkg::NUM_FIELDS],
  output logic signed [COORD_WIDTH:0]            d   [sit_pkg::NUM_ORIENT][4],
  output logic [sit_pkg::NUM_ORIENT-1:0]         box
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int FW = sit_pkg::FIELD_WIDTH;

  logic signed [COORD_WIDTH-1:0] crd [sit_pkg::NUM_FIELDS];

  for (genvar i = 0; i < sit_pkg::NUM_FIELDS; i++) begin : g_coord
    if (COORD_WIDTH <= FW) begin : g_narrow
      assign crd[i] = fld[i][COORD_WIDTH-1:0];
    end else begin : g_wide
      // field bits above the top are zero, so the value is never negative
      assign crd[i] = {{(COORD_WIDTH-FW){1'b0}}, fld[i]};
    end
  end

  function automatic logic signed [DW-1:0] dif(input logic signed [COORD_WIDTH-1:0] a,
                                               input logic signed [COORD_WIDTH-1:0] b);
    dif = DW'(a) - DW'(b);
  endfunction

  // q inside the closed box spanned by p and r
  function automatic logic in_box(input logic signed [COORD_WIDTH-1:0] px,
                                  input logic signed [COORD_WIDTH-1:0] py,
                                  input logic signed [COORD_WIDTH-1:0] qx,
                                  input logic signed [COORD_WIDTH-1:0] qy,
                                  input logic signed [COORD_WIDTH-1:0] rx,
                                  input logic signed [COORD_WIDTH-1:0] ry);
    in_box = ((qx >= px) || (qx >= rx)) && ((qx <= px) || (qx <= rx)) &&
             ((qy >= py) || (qy >= ry)) && ((qy <= py) || (qy <= ry));
  endfunction

  // crd order: a start x/y, a end x/y, b start x/y, b end x/y
  always_ff @(posedge clk) begin
    if (en.s1) begin
      // A0 A1 against B0
      d[0][0] <= dif(crd[3], crd[1]);
      d[0][1] <= dif(crd[4], crd[2]);
      d[0][2] <= dif(crd[2], crd[0]);
      d[0][3] <= dif(crd[5], crd[3]);
      // A0 A1 against B1
      d[1][0] <= dif(crd[3], crd[1]);
      d[1][1] <= dif(crd[6], crd[2]);
      d[1][2] <= dif(crd[2], crd[0]);
      d[1][3] <= dif(crd[7], crd[3]);
      // B0 B1 against A0
      d[2][0] <= dif(crd[7], crd[5]);
      d[2][1] <= dif(crd[0], crd[6]);
      d[2][2] <= dif(crd[6], crd[4]);
      d[2][3] <= dif(crd[1], crd[7]);
      // B0 B1 against A1
      d[3][0] <= dif(crd[7], crd[5]);
      d[3][1] <= dif(crd[2], crd[6]);
      d[3][2] <= dif(crd[6], crd[4]);
      d[3][3] <= dif(crd[3], crd[7]);
      box[0] <= in_box(crd[0], crd[1], crd[4], crd[5], crd[2], crd[3]);
      box[1] <= in_box(crd[0], crd[1], crd[6], crd[7], crd[2], crd[3]);
      box[2] <= in_box(crd[4], crd[5], crd[0], crd[1], crd[6], crd[7]);
      box[3] <= in_box(crd[4], crd[5], crd[2], crd[3], crd[6], crd[7]);
    end
  end

endmodule

// File: rtl/core/sit_orient.sv
// Stages 2 and 3: one orientation sign from two products and their difference
module sit_orient #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  sit_pkg::stage_en_t            en,
  input  logic signed [COORD_WIDTH:0]   d [4],
  output sit_pkg::orient_t              code
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] prod_l;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] mul_l;
  logic signed [PW-1:0] mul_r;
  logic signed [SW-1:0] diff;

  assign mul_l = PW'(d[0]) * PW'(d[1]);
  assign mul_r = PW'(d[2]) * PW'(d[3]);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_l <= mul_l;
      prod_r <= mul_r;
    end
  end

  assign diff = SW'(prod_l) - SW'(prod_r);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      if (diff == '0) begin
        code <= sit_pkg::ORIENT_COLLINEAR;
      end else if (diff[SW-1]) begin
        code <= sit_pkg::ORIENT_NEG;
      end else begin
        code <= sit_pkg::ORIENT_POS;
      end
    end
  end

endmodule

// File: rtl/core/sit_decide.sv
// Stage 4: combine orientation signs and box tests into the result register
module sit_decide (
  input  logic                               clk,
  input  sit_pkg::stage_en_t                 en,
  input  sit_pkg::orient_t                   code [sit_pkg::NUM_ORIENT],
  input  logic [sit_pkg::NUM_ORIENT-1:0]     box,
  output logic                               meet
);

  logic meet_next;

  always_comb begin
    // proper crossing, or a collinear endpoint lying on the other segment
    meet_next = ((code[0] != code[1]) && (code[2] != code[3])) ||
                ((code[0] == sit_pkg::ORIENT_COLLINEAR) && box[0]) ||
                ((code[1] == sit_pkg::ORIENT_COLLINEAR) && box[1]) ||
                ((code[2] == sit_pkg::ORIENT_COLLINEAR) && box[2]) ||
                ((code[3] == sit_pkg::ORIENT_COLLINEAR) && box[3]);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      meet <= meet_next;
    end
  end

endmodule
